FILE: rtl/dfhm_pkg.sv
// ----------------------------------------------------------------------------
// dfhm_pkg: shared types and constants for the door forced/held monitor
// Sample, result and state records, event and register codes, time widths.
// ----------------------------------------------------------------------------
package dfhm_pkg;

  // Width of the internal timestamps; all time differences wrap at this width
  localparam int TIME_BITS = 32;
  // Width used for the duration and limit compares
  localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam int NOW_W      = 32;
  localparam int LIMIT_W    = 32;
  localparam int DEBOUNCE_W = 16;
  localparam int DUR_W      = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = '0;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    EV_NONE        = 2'd0,
    EV_FORCED      = 2'd1,
    EV_HELD        = 2'd2,
    EV_HELD_CLOSED = 2'd3
  } event_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HELD_LIMIT = 1'b0,
    REG_DEBOUNCE   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_UPDATE = 1'b0,
    MODE_INIT   = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [NOW_W-1:0]  now_ms;
    logic              raw_open;
    logic              released;
    logic              schedule_open;
  } sample_t;

  typedef struct packed {
    logic [1:0]        event_res;
    logic              door_open;
    logic [DUR_W-1:0]  last_open_duration;
  } result_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]    held_limit_ms;
    logic [DEBOUNCE_W-1:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    logic  stable_open;
    logic  change_pending;
    time_t pending_start;
    time_t open_start;
    logic  held_timing;
    time_t held_start;
    logic  held_reported;
    logic  forced_flag;
    time_t last_duration;
  } state_t;

endpackage

FILE: rtl/dfhm_if.sv
// ----------------------------------------------------------------------------
// dfhm_if: valid/ready channels of the door forced/held monitor
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface dfhm_sample_if
  import dfhm_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dfhm_result_if
  import dfhm_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dfhm_cfg_if
  import dfhm_pkg::*;
;
  logic       valid;
  logic       ready;
  cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/door_forced_held_monitor_core.sv
// ----------------------------------------------------------------------------
// door_forced_held_monitor_core: door contact supervisor
// Debounces the door contact and reports forced, held and held-closed events.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one contact sample per item (mode, now_ms, raw_open, released,
//            schedule_open). Mode init loads the state from the sample.
//   result : exactly one item per sample (event_res, door_open,
//            last_open_duration), in sample order.
//   cfg    : register writes, always ready; index 0 is held_limit_ms,
//            index 1 is settle_ms. Write only while no sample is in flight.
// Path: an accepted sample goes into the input register, and its result
//   into the result register, where it waits until taken.
// Throughput: one sample per cycle while results are taken; the step logic
//   between the two registers is a few 32-bit subtracts and compares.
// Reset (rst, synchronous): clears the state, empties both registers and
//   sets held_limit_ms to 0 (held detection off) and settle_ms to 50.
// Stall: while the result is held, one more sample is taken into the input
//   register; after that sample.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module door_forced_held_monitor_core
  import dfhm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dfhm_cfg_if.sink    cfg,
  dfhm_sample_if.sink sample,
  dfhm_result_if.source result
);

  cfg_t    cfg_regs;
  state_t  st;
  state_t  st_next;
  sample_t smp;
  logic    smp_valid;
  result_t res_next;
  result_t res;
  logic    res_valid;
  logic    advance;

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.held_limit_ms <= LIMIT_RESET;
      cfg_regs.settle_ms     <= DEBOUNCE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.data.addr))
        REG_HELD_LIMIT: cfg_regs.held_limit_ms <= LIMIT_W'(cfg.data.data);
        REG_DEBOUNCE:   cfg_regs.settle_ms     <= DEBOUNCE_W'(cfg.data.data);
        default:        cfg_regs               <= cfg_regs;
      endcase
    end
  end

  // Move the registered sample into the result register when it has room
  assign advance      = smp_valid && (!res_valid || result.ready);
  assign sample.ready = !smp_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (sample.ready) begin
      smp_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      smp <= sample.data;
    end
  end

  dfhm_step u_step (
    .st      (st),
    .cfg     (cfg_regs),
    .smp     (smp),
    .st_next (st_next),
    .res     (res_next)
  );

  // Commit the state once per processed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res;

  // A held report only exists while the door is open
  a_held_needs_open: assert property (@(posedge clk) disable iff (rst)
    st.held_reported |-> st.stable_open)
    else $error("held reported while door closed");

  // Held timing only runs while the door is open
  a_timing_needs_open: assert property (@(posedge clk) disable iff (rst)
    st.held_timing |-> st.stable_open)
    else $error("held timing while door closed");

  // Open events come with an open door, held-closed with a closed one
  a_event_door: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.event_res == EV_FORCED || res.event_res == EV_HELD)
      |-> res.door_open)
    else $error("open event with closed door");

  a_closed_event_door: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.event_res == EV_HELD_CLOSED) |-> !res.door_open)
    else $error("held-closed event with open door");

  // Every processed sample leaves a result behind
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed sample produced no result");

endmodule

FILE: rtl/dfhm_step.sv
// ----------------------------------------------------------------------------
// dfhm_step: next-state and event logic for one contact sample
// Debounce, forced-open detection, held-open timing and duration capture.
// ----------------------------------------------------------------------------
module dfhm_step
  import dfhm_pkg::*;
(
  input  state_t  st,
  input  cfg_t    cfg,
  input  sample_t smp,
  output state_t  st_next,
  output result_t res
);

  time_t  now;
  time_t  diff_pend;
  time_t  diff_open;
  time_t  diff_held;
  logic   auth;
  logic   changed;
  logic   debounce_done;
  logic   held_due;
  event_t ev;

  // Wrapped elapsed times against each stored start
  assign now       = TIME_BITS'(smp.now_ms);
  assign auth      = smp.released | smp.schedule_open;
  assign diff_pend = now - st.pending_start;
  assign diff_open = now - st.open_start;
  assign diff_held = now - st.held_start;

  assign debounce_done = CMP_BITS'(diff_pend) >= CMP_BITS'(cfg.settle_ms);
  assign held_due      = (cfg.held_limit_ms != '0) &&
                         (CMP_BITS'(diff_held) >= CMP_BITS'(cfg.held_limit_ms));

  always_comb begin
    st_next = st;
    ev      = EV_NONE;
    changed = 1'b0;
    if (smp.mode == MODE_INIT) begin
      // Load state straight from the sample
      st_next.stable_open    = smp.raw_open;
      st_next.change_pending = 1'b0;
      st_next.pending_start  = '0;
      st_next.open_start     = now;
      st_next.held_timing    = smp.raw_open;
      st_next.held_start     = now;
      st_next.held_reported  = 1'b0;
      st_next.forced_flag    = 1'b0;
      st_next.last_duration  = '0;
    end else begin
      // Debounce: a difference must persist for the window
      if (smp.raw_open != st.stable_open) begin
        if (!st.change_pending) begin
          st_next.change_pending = 1'b1;
          st_next.pending_start  = now;
        end else if (debounce_done) begin
          st_next.change_pending = 1'b0;
          st_next.stable_open    = smp.raw_open;
          changed                = 1'b1;
        end
      end else begin
        st_next.change_pending = 1'b0;
      end

      if (changed && smp.raw_open) begin
        // Opening accepted: report forced when not authorized
        st_next.open_start    = now;
        st_next.held_reported = 1'b0;
        st_next.forced_flag   = !auth;
        st_next.held_timing   = !auth;
        st_next.held_start    = now;
        ev                    = auth ? EV_NONE : EV_FORCED;
      end else if (changed) begin
        // Closing accepted: capture duration, close a held episode
        st_next.last_duration = diff_open;
        st_next.held_timing   = 1'b0;
        st_next.held_reported = 1'b0;
        st_next.forced_flag   = 1'b0;
        ev                    = st.held_reported ? EV_HELD_CLOSED : EV_NONE;
      end else if (st.stable_open) begin
        // Door stays open: time the unauthorized stretch
        if (auth) begin
          st_next.held_timing = 1'b0;
        end else if (!st.held_timing) begin
          st_next.held_timing = 1'b1;
          st_next.held_start  = now;
        end else if (!st.held_reported && held_due) begin
          st_next.held_reported = 1'b1;
          ev                    = EV_HELD;
        end
      end
    end
  end

  // Result fields follow the updated state
  always_comb begin
    res.event_res          = ev;
    res.door_open          = st_next.stable_open;
    res.last_open_duration = DUR_W'(st_next.last_duration);
  end

endmodule
